>>> hdl/acfp_pkg.sv
// Package for the ASCII CAN frame text parser.
// Holds the result record type, character codes, payload limits and hex decode.
// No dependencies.
`timescale 1ns / 1ps

package acfp_pkg;

  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_R_UC = 8'h52;
  localparam logic [7:0] CHAR_R_LC = 8'h72;

  localparam logic [6:0] MAX_CLASSIC_BYTES = 7'd8;
  localparam logic [6:0] MAX_FD_BYTES      = 7'd64;

  localparam logic [1:0] ST_CLASSIC_OK = 2'd0;
  localparam logic [1:0] ST_FD_OK      = 2'd1;
  localparam logic [1:0] ST_BAD        = 2'd2;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int unsigned TDATA_W = 64;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;
    logic [31:0] can_id_word;
    logic [3:0]  fd_flags;
    logic [6:0]  data_len;
    logic [1:0]  status;
    logic        run_last;
  } acfp_rec_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] acfp_hex(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

>>> hdl/acfp_parser.sv
// Character-step parser: frame state registers and the per-character update.
// Produces up to two result records per character. Depends on acfp_pkg.
`timescale 1ns / 1ps

module acfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  input  logic              eot_i,
  output acfp_pkg::acfp_rec_t rec0_o,
  output acfp_pkg::acfp_rec_t rec1_o,
  output logic [1:0]        push_cnt_o
);
  import acfp_pkg::*;

  localparam logic [3:0] PH_ID     = 4'd0;
  localparam logic [3:0] PH_DELIM  = 4'd1;
  localparam logic [3:0] PH_RLEN   = 4'd2;
  localparam logic [3:0] PH_RDONE  = 4'd3;
  localparam logic [3:0] PH_FLAGS  = 4'd4;
  localparam logic [3:0] PH_HI     = 4'd5;
  localparam logic [3:0] PH_HI_DOT = 4'd6;
  localparam logic [3:0] PH_LO     = 4'd7;
  localparam logic [3:0] PH_FULL   = 4'd8;
  localparam logic [3:0] PH_BAD    = 4'd9;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  char_count_q, char_count_d;
  logic [31:0] id_accum_q, id_accum_d;
  logic [3:0]  flag_nibble_q, flag_nibble_d;
  logic [6:0]  byte_count_q, byte_count_d;
  logic [3:0]  high_nibble_q, high_nibble_d;
  logic        is_fd_q, is_fd_d;
  logic [3:0]  remote_len_q, remote_len_d;

  logic [4:0]  hex;
  logic        is_hex;
  logic [3:0]  nib;
  logic [6:0]  limit;
  logic        byte_v;
  logic        sum_ok;
  acfp_rec_t   byte_rec;
  acfp_rec_t   sum_rec;

  assign hex    = acfp_hex(char_i);
  assign is_hex = ~hex[4];
  assign nib    = hex[3:0];
  assign limit  = is_fd_q ? MAX_FD_BYTES : MAX_CLASSIC_BYTES;

  always_comb begin
    phase_d       = phase_q;
    char_count_d  = char_count_q;
    id_accum_d    = id_accum_q;
    flag_nibble_d = flag_nibble_q;
    byte_count_d  = byte_count_q;
    high_nibble_d = high_nibble_q;
    is_fd_d       = is_fd_q;
    remote_len_d  = remote_len_q;
    byte_v        = 1'b0;
    byte_rec      = '0;
    byte_rec.result_kind = KIND_BYTE;
    byte_rec.byte_index  = byte_count_q[5:0];
    byte_rec.byte_value  = {high_nibble_q, nib};
    byte_rec.run_last    = ~eot_i;

    unique case (phase_q)
      PH_ID: begin
        if (char_count_q != 4'd15) begin
          char_count_d = char_count_q + 4'd1;
        end
        if ((char_count_q == 4'd3 || char_count_q == 4'd8) && char_i == CHAR_HASH) begin
          if (char_count_q == 4'd8 && !id_accum_q[29]) begin
            id_accum_d[31] = 1'b1;
          end
          phase_d = PH_DELIM;
        end else if (char_count_q < 4'd8 && is_hex) begin
          id_accum_d = {id_accum_q[27:0], nib};
        end else begin
          phase_d = PH_BAD;
        end
      end
      PH_DELIM: begin
        if (char_i == CHAR_R_UC || char_i == CHAR_R_LC) begin
          id_accum_d[30] = 1'b1;
          phase_d        = PH_RLEN;
        end else if (char_i == CHAR_HASH) begin
          is_fd_d = 1'b1;
          phase_d = PH_FLAGS;
        end else if (char_i == CHAR_DOT) begin
          phase_d = PH_HI_DOT;
        end else if (!is_hex) begin
          phase_d = PH_BAD;
        end else begin
          high_nibble_d = nib;
          phase_d       = PH_LO;
        end
      end
      PH_RLEN: begin
        if (is_hex && nib <= 4'd8) begin
          remote_len_d = nib;
        end
        phase_d = PH_RDONE;
      end
      PH_FLAGS: begin
        if (!is_hex) begin
          phase_d = PH_BAD;
        end else begin
          flag_nibble_d = nib;
          phase_d       = PH_HI;
        end
      end
      PH_HI: begin
        if (char_i == CHAR_DOT) begin
          phase_d = PH_HI_DOT;
        end else if (!is_hex) begin
          phase_d = PH_BAD;
        end else begin
          high_nibble_d = nib;
          phase_d       = PH_LO;
        end
      end
      PH_HI_DOT: begin
        if (!is_hex) begin
          phase_d = PH_BAD;
        end else begin
          high_nibble_d = nib;
          phase_d       = PH_LO;
        end
      end
      PH_LO: begin
        if (!is_hex) begin
          phase_d = PH_BAD;
        end else begin
          byte_v       = 1'b1;
          byte_count_d = byte_count_q + 7'd1;
          phase_d      = (byte_count_d >= limit) ? PH_FULL : PH_HI;
        end
      end
      default: begin
      end
    endcase
  end

  assign sum_ok = (phase_d == PH_DELIM) || (phase_d == PH_RLEN) || (phase_d == PH_RDONE) ||
                  (phase_d == PH_HI) || (phase_d == PH_HI_DOT) || (phase_d == PH_FULL);

  always_comb begin
    sum_rec             = '0;
    sum_rec.result_kind = KIND_SUMMARY;
    sum_rec.run_last    = 1'b1;
    sum_rec.status      = ST_BAD;
    if (sum_ok) begin
      sum_rec.can_id_word = id_accum_d;
      if (id_accum_d[30] && !is_fd_d) begin
        sum_rec.data_len = {3'd0, remote_len_d};
        sum_rec.status   = ST_CLASSIC_OK;
      end else begin
        sum_rec.data_len = byte_count_d;
        sum_rec.fd_flags = is_fd_d ? flag_nibble_d : 4'd0;
        sum_rec.status   = is_fd_d ? ST_FD_OK : ST_CLASSIC_OK;
      end
    end
  end

  assign rec0_o     = byte_v ? byte_rec : sum_rec;
  assign rec1_o     = sum_rec;
  assign push_cnt_o = step_i ? ({1'b0, byte_v} + {1'b0, eot_i}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_ID;
      char_count_q  <= '0;
      id_accum_q    <= '0;
      flag_nibble_q <= '0;
      byte_count_q  <= '0;
      high_nibble_q <= '0;
      is_fd_q       <= 1'b0;
      remote_len_q  <= '0;
    end else if (step_i) begin
      if (eot_i) begin
        phase_q       <= PH_ID;
        char_count_q  <= '0;
        id_accum_q    <= '0;
        flag_nibble_q <= '0;
        byte_count_q  <= '0;
        high_nibble_q <= '0;
        is_fd_q       <= 1'b0;
        remote_len_q  <= '0;
      end else begin
        phase_q       <= phase_d;
        char_count_q  <= char_count_d;
        id_accum_q    <= id_accum_d;
        flag_nibble_q <= flag_nibble_d;
        byte_count_q  <= byte_count_d;
        high_nibble_q <= high_nibble_d;
        is_fd_q       <= is_fd_d;
        remote_len_q  <= remote_len_d;
      end
    end
  end

endmodule

>>> hdl/acfp_out_fifo.sv
// Four-entry result queue taking up to two records per cycle, one out per cycle
// while ready_i is high. Depends on acfp_pkg.
`timescale 1ns / 1ps

module acfp_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acfp_pkg::acfp_rec_t rec0_i,
  input  acfp_pkg::acfp_rec_t rec1_i,
  input  logic [1:0]          push_cnt_i,
  output logic                room2_o,
  output logic                valid_o,
  input  logic                ready_i,
  output acfp_pkg::acfp_rec_t head_o
);
  import acfp_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  acfp_rec_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q;
  logic                pop;
  logic [PtrW-1:0]     wr_ptr1;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign room2_o = (count_q <= (PtrW+1)'(Depth - 2));
  assign wr_ptr1 = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= rec0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr1] <= rec1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (PtrW+1)'(push_cnt_i) - (PtrW+1)'(pop);
    end
  end

endmodule

>>> hdl/ascii_can_frame_parser_top.sv
// Top level of the ASCII CAN frame text parser: stream ports, parser and result queue.
// Depends on acfp_pkg, acfp_parser and acfp_out_fifo.
//
// One text character is taken per transfer (tlast marks the end of the text), and a new
// character is accepted every cycle while the four-entry result queue has room for two
// records. Each completed data byte enters the queue as a byte record when its second
// nibble is taken; the last character also yields a summary record with the id word,
// length, FD flags and status. A character that both completes a byte and ends the text
// yields two records, drained one per cycle while m_axis_tready is high. After a
// summary with bad-format status, the byte records of that frame are to be discarded.
`timescale 1ns / 1ps

module ascii_can_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // byte_index, byte_value, can_id_word, fd_flags,
                                      // data_len, status, zero fill
  output logic [0:0]  m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // run_last
);
  import acfp_pkg::*;

  acfp_rec_t  rec0, rec1, head;
  logic [1:0] push_cnt;
  logic       room2;
  logic       step;

  assign s_axis_tready = room2;
  assign step          = s_axis_tvalid && room2;

  acfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .char_i     (s_axis_tdata),
    .eot_i      (s_axis_tlast),
    .rec0_o     (rec0),
    .rec1_o     (rec1),
    .push_cnt_o (push_cnt)
  );

  acfp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec0_i     (rec0),
    .rec1_i     (rec1),
    .push_cnt_i (push_cnt),
    .room2_o    (room2),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .head_o     (head)
  );

  assign m_axis_tdata = {5'd0, head.status, head.data_len, head.fd_flags,
                         head.can_id_word, head.byte_value, head.byte_index};
  assign m_axis_tuser = head.result_kind;
  assign m_axis_tlast = head.run_last;

endmodule

>>> hdl/acfp_checker.sv
// Port-level checks for the ASCII CAN frame text parser, bound to the top level.
// Depends on ascii_can_frame_parser_top.
`timescale 1ns / 1ps

module acfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_i,
  input logic [0:0]  m_axis_tuser_i,
  input logic        m_axis_tlast_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result dropped while stalled");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i[0] |-> m_axis_tlast_i)
    else $error("summary not marked last");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i[0] |-> m_axis_tdata_i[63:14] == 50'd0)
    else $error("byte record carries summary fields");

  a_summary_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i[0] |->
      m_axis_tdata_i[58:57] != 2'd3 && m_axis_tdata_i[56:50] <= 7'd64 &&
      m_axis_tdata_i[13:0] == 14'd0)
    else $error("summary fields out of range");

endmodule

bind ascii_can_frame_parser_top acfp_checker u_acfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata),
  .m_axis_tuser_i  (m_axis_tuser),
  .m_axis_tlast_i  (m_axis_tlast)
);
